// ===== design/sra_pkg.sv =====
// shared types and constants of the slot range allocator
`timescale 1ns / 1ps

package sra_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int CHANNELS_DEF = 255;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_CHANNEL  = 2'd3;

    // mark bits of a table entry
    localparam logic [1:0] MARK_FIRST = 2'b01;
    localparam logic [1:0] MARK_LAST  = 2'b10;

    // what the datapath does with each slot visited in a pass
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHECK,
        OP_WRITE,
        OP_REMOVE,
        OP_REPORT,
        OP_MARK,
        OP_READ
    } pass_op_t;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        pass_op_t op;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       ch_ok;
        logic       rng_ok;
        logic       rd_ok;
        logic       found;
    } dp_stat_t;

endpackage

// ===== design/sra_dpath.sv =====
// datapath of the slot range allocator: slot table, pass processing, result registers
`timescale 1ns / 1ps

module sra_dpath
    import sra_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    input  logic [IW-1:0] rd_idx,
    output dp_stat_t      stat,
    output logic [IW-1:0] lo_idx,
    output logic [IW-1:0] hi_idx,
    input  logic [1:0]    in_req_type,
    input  logic [15:0]   in_channel,
    input  logic [6:0]    in_start_slot,
    input  logic [6:0]    in_end_slot,
    output logic [1:0]    status,
    output logic [5:0]    conflict_slot,
    output logic [5:0]    removed_count,
    output logic [5:0]    empty_count,
    output logic [5:0]    foreign_count,
    output logic [31:0]   owned_mask,
    output logic [5:0]    first_owned,
    output logic [5:0]    last_owned,
    output logic [15:0]   slot_owner,
    output logic          slot_first,
    output logic          slot_last
);

    // request latched at accept
    logic [1:0]    req_reg;
    logic [15:0]   ch_reg;
    logic [IW-1:0] lo_reg;
    logic [IW-1:0] hi_reg;
    logic          ch_ok_reg;
    logic          rng_ok_reg;
    logic          rd_ok_reg;

    logic [6:0] s_m1;
    logic [6:0] e_m1;

    // slot table: owner in [17:2], marks in [1:0]
    logic [17:0]      mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic [17:0]      rd_data_reg;
    logic             rd_vld_reg;

    // processing stage, in the cycle after the read address
    logic          proc_reg;
    pass_op_t      proc_op_reg;
    logic [IW-1:0] proc_idx_reg;

    logic [15:0] own;
    logic [1:0]  mrk;
    logic [6:0]  idx7;
    logic [5:0]  slot6;

    logic        wr_en;
    logic [17:0] wr_data;
    logic [1:0]  wr_mark;

    // accumulators
    logic          found_reg;
    logic [5:0]    conflict_reg;
    logic [5:0]    removed_reg;
    logic [5:0]    empty_reg;
    logic [5:0]    foreign_reg;
    logic [31:0]   mask_reg;
    logic [5:0]    first_reg;
    logic [5:0]    last_reg;
    logic          any_reg;
    logic [IW-1:0] first_idx_reg;
    logic [IW-1:0] last_idx_reg;
    logic [15:0]   sown_reg;
    logic          sfirst_reg;
    logic          slast_reg;

    logic [1:0] status_next;

    // result registers
    logic [1:0]  out_status_reg;
    logic [5:0]  out_conflict_reg;
    logic [5:0]  out_removed_reg;
    logic [5:0]  out_empty_reg;
    logic [5:0]  out_foreign_reg;
    logic [31:0] out_mask_reg;
    logic [5:0]  out_first_reg;
    logic [5:0]  out_last_reg;
    logic [15:0] out_sown_reg;
    logic        out_sfirst_reg;
    logic        out_slast_reg;

    assign s_m1 = in_start_slot - 7'd1;
    assign e_m1 = in_end_slot - 7'd1;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= in_req_type;
            ch_reg     <= in_channel;
            lo_reg     <= s_m1[IW-1:0];
            hi_reg     <= e_m1[IW-1:0];
            ch_ok_reg  <= (in_channel != 16'd0) && (in_channel <= 16'(CHANNELS));
            rng_ok_reg <= (in_start_slot != 7'd0) && (in_end_slot <= 7'(SLOTS))
                          && (in_start_slot <= in_end_slot);
            rd_ok_reg  <= (in_start_slot != 7'd0) && (in_start_slot <= 7'(SLOTS));
        end
    end

    assign stat.req    = req_reg;
    assign stat.ch_ok  = ch_ok_reg;
    assign stat.rng_ok = rng_ok_reg;
    assign stat.rd_ok  = rd_ok_reg;
    assign stat.found  = found_reg;
    assign lo_idx      = lo_reg;
    assign hi_idx      = hi_reg;

    // entries never written read as empty
    assign own   = rd_vld_reg ? rd_data_reg[17:2] : 16'd0;
    assign mrk   = rd_vld_reg ? rd_data_reg[1:0] : 2'b00;
    assign idx7  = 7'(proc_idx_reg);
    assign slot6 = 6'(idx7 + 7'd1);

    always_comb begin
        wr_mark = 2'b00;
        if (proc_idx_reg == first_idx_reg) begin
            wr_mark = wr_mark | MARK_FIRST;
        end
        if (proc_idx_reg == last_idx_reg) begin
            wr_mark = wr_mark | MARK_LAST;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (proc_reg) begin
            case (proc_op_reg)
                OP_WRITE: begin
                    wr_en   = 1'b1;
                    wr_data = {ch_reg, 2'b00};
                end
                OP_REMOVE: begin
                    wr_en   = (own == ch_reg);
                    wr_data = '0;
                end
                OP_MARK: begin
                    wr_en   = (own == ch_reg);
                    wr_data = {ch_reg, wr_mark};
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[proc_idx_reg] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_idx];
            rd_vld_reg  <= vld_reg[rd_idx];
        end
        proc_op_reg  <= cmd.op;
        proc_idx_reg <= rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            proc_reg <= 1'b0;
        end else begin
            proc_reg <= cmd.rd_en;
            if (wr_en) begin
                vld_reg[proc_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            found_reg     <= 1'b0;
            conflict_reg  <= '0;
            removed_reg   <= '0;
            empty_reg     <= '0;
            foreign_reg   <= '0;
            mask_reg      <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            any_reg       <= 1'b0;
            first_idx_reg <= '0;
            last_idx_reg  <= '0;
            sown_reg      <= '0;
            sfirst_reg    <= 1'b0;
            slast_reg     <= 1'b0;
        end else if (proc_reg) begin
            case (proc_op_reg)
                OP_CHECK: begin
                    if (own != 16'd0 && own != ch_reg && !found_reg) begin
                        found_reg    <= 1'b1;
                        conflict_reg <= slot6;
                    end
                end
                OP_REMOVE: begin
                    if (own == ch_reg) begin
                        removed_reg <= removed_reg + 6'd1;
                    end else if (own == 16'd0) begin
                        empty_reg <= empty_reg + 6'd1;
                    end else begin
                        foreign_reg <= foreign_reg + 6'd1;
                    end
                end
                OP_REPORT: begin
                    if (own == ch_reg) begin
                        if (idx7 < 7'd32) begin
                            mask_reg[idx7[4:0]] <= 1'b1;
                        end
                        if (!any_reg) begin
                            first_reg     <= slot6;
                            first_idx_reg <= proc_idx_reg;
                        end
                        any_reg      <= 1'b1;
                        last_reg     <= slot6;
                        last_idx_reg <= proc_idx_reg;
                    end
                end
                OP_READ: begin
                    sown_reg   <= own;
                    sfirst_reg <= (mrk & MARK_FIRST) != 2'b00;
                    slast_reg  <= (mrk & MARK_LAST) != 2'b00;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (req_reg == REQ_READ) begin
            status_next = rd_ok_reg ? ST_OK : ST_RANGE;
        end else if (!ch_ok_reg) begin
            status_next = ST_CHANNEL;
        end else if (!rng_ok_reg && (req_reg == REQ_ADD || req_reg == REQ_REMOVE)) begin
            status_next = ST_RANGE;
        end else if (req_reg == REQ_ADD && found_reg) begin
            status_next = ST_CONFLICT;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg   <= status_next;
            out_conflict_reg <= conflict_reg;
            out_removed_reg  <= removed_reg;
            out_empty_reg    <= empty_reg;
            out_foreign_reg  <= foreign_reg;
            out_mask_reg     <= mask_reg;
            out_first_reg    <= first_reg;
            out_last_reg     <= last_reg;
            out_sown_reg     <= sown_reg;
            out_sfirst_reg   <= sfirst_reg;
            out_slast_reg    <= slast_reg;
        end
    end

    assign status        = out_status_reg;
    assign conflict_slot = out_conflict_reg;
    assign removed_count = out_removed_reg;
    assign empty_count   = out_empty_reg;
    assign foreign_count = out_foreign_reg;
    assign owned_mask    = out_mask_reg;
    assign first_owned   = out_first_reg;
    assign last_owned    = out_last_reg;
    assign slot_owner    = out_sown_reg;
    assign slot_first    = out_sfirst_reg;
    assign slot_last     = out_slast_reg;

endmodule

// ===== design/sra_ctrl.sv =====
// controller of the slot range allocator: request sequencing and slot passes
`timescale 1ns / 1ps

module sra_ctrl
    import sra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  dp_stat_t      stat,
    input  logic [IW-1:0] lo_idx,
    input  logic [IW-1:0] hi_idx,
    output dp_cmd_t       cmd,
    output logic [IW-1:0] rd_idx
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_CHECK  = 10'b0000000100,
        S_CHKEND = 10'b0000001000,
        S_WRITE  = 10'b0000010000,
        S_REMOVE = 10'b0000100000,
        S_REPORT = 10'b0001000000,
        S_MARK   = 10'b0010000000,
        S_READ   = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] end_reg, end_next;
    logic          drain_reg, drain_next;
    logic          mtv_reg, mtv_next;
    logic          in_pass;

    assign in_pass = (state_reg == S_CHECK) || (state_reg == S_WRITE)
                  || (state_reg == S_REMOVE) || (state_reg == S_REPORT)
                  || (state_reg == S_MARK) || (state_reg == S_READ);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        drain_next   = drain_reg;
        cmd.load     = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;

        // address stepping shared by all passes, each pass ending in a drain step
        if (in_pass && !drain_reg) begin
            cmd.rd_en = 1'b1;
            if (cnt_reg == end_reg) begin
                drain_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + IW'(1);
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                drain_next = 1'b0;
                cnt_next   = '0;
                end_next   = LAST_IDX;
                if (stat.req == REQ_READ) begin
                    cnt_next   = lo_idx;
                    end_next   = lo_idx;
                    state_next = stat.rd_ok ? S_READ : S_FIN;
                end else if (!stat.ch_ok) begin
                    state_next = S_FIN;
                end else if (stat.req == REQ_ADD && stat.rng_ok) begin
                    cnt_next   = lo_idx;
                    end_next   = hi_idx;
                    state_next = S_CHECK;
                end else if (stat.req == REQ_REMOVE && stat.rng_ok) begin
                    cnt_next   = lo_idx;
                    end_next   = hi_idx;
                    state_next = S_REMOVE;
                end else begin
                    state_next = S_REPORT;
                end
            end
            S_CHECK: begin
                cmd.op = OP_CHECK;
                if (drain_reg) begin
                    state_next = S_CHKEND;
                end
            end
            S_CHKEND: begin
                drain_next = 1'b0;
                if (stat.found) begin
                    cnt_next   = '0;
                    end_next   = LAST_IDX;
                    state_next = S_REPORT;
                end else begin
                    cnt_next   = lo_idx;
                    end_next   = hi_idx;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.op = OP_WRITE;
                if (drain_reg) begin
                    drain_next = 1'b0;
                    cnt_next   = '0;
                    end_next   = LAST_IDX;
                    state_next = S_REPORT;
                end
            end
            S_REMOVE: begin
                cmd.op = OP_REMOVE;
                if (drain_reg) begin
                    drain_next = 1'b0;
                    cnt_next   = '0;
                    end_next   = LAST_IDX;
                    state_next = S_REPORT;
                end
            end
            S_REPORT: begin
                cmd.op = OP_REPORT;
                if (drain_reg) begin
                    drain_next = 1'b0;
                    cnt_next   = '0;
                    end_next   = LAST_IDX;
                    state_next = S_MARK;
                end
            end
            S_MARK: begin
                cmd.op = OP_MARK;
                if (drain_reg) begin
                    drain_next = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_READ: begin
                cmd.op = OP_READ;
                if (drain_reg) begin
                    drain_next = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!mtv_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mtv_next = mtv_reg;
        if (cmd.out_load) begin
            mtv_next = 1'b1;
        end else if (m_tready) begin
            mtv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
            mtv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            mtv_reg   <= mtv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        end_reg <= end_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mtv_reg;
    assign rd_idx   = cnt_reg;

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mtv_reg || m_tready))
        else $error("result loaded over a pending result");

    // an accepted item is decoded in the next cycle
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    // a new result only appears from the finish state
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mtv_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish state");

    // no table read is issued outside a pass or in its drain cycle
    a_read_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (in_pass && !drain_reg))
        else $error("table read outside a pass");

endmodule

// ===== design/slot_range_allocator.sv =====
// top level of the slot range allocator: stream ports, controller and datapath
//
// channel  | direction | payload
// ---------+-----------+-----------------------------------------------------
// s_       | in        | request item: tuser request type, tdata channel and range
// m_       | out       | result item: status, counts, channel mask, slot entry
//
// one item at a time; each request runs as passes over the slot table through
// its single read and single write port, one slot per cycle and a drain step at the
// end of each pass; add checks its range and writes it unless a slot conflicts, remove
// clears its own slots in the range, then add, remove and query report and mark over
// the whole table; a read visits its one slot, a bad channel or read slot none
// reset clears the slot valid bits at once, so all slots read as empty
// s_tready is high only while idle; a result waits in the output register
// while the next item is accepted, and a later result waits for m_tready
`timescale 1ns / 1ps

module slot_range_allocator
    import sra_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[15:0], start_slot[22:16], end_slot[29:23], zeros
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // status[1:0], conflict_slot[7:2], removed_count[13:8],
                                   // empty_count[19:14], foreign_count[25:20],
                                   // owned_mask[57:26], first_owned[63:58],
                                   // last_owned[69:64], slot_owner[85:70],
                                   // slot_first[86], slot_last[87]
);

    // table index width
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] lo_idx;
    logic [IW-1:0] hi_idx;

    logic [1:0]  status;
    logic [5:0]  conflict_slot;
    logic [5:0]  removed_count;
    logic [5:0]  empty_count;
    logic [5:0]  foreign_count;
    logic [31:0] owned_mask;
    logic [5:0]  first_owned;
    logic [5:0]  last_owned;
    logic [15:0] slot_owner;
    logic        slot_first;
    logic        slot_last;

    // sequencer: accepts requests, steps the slot passes, releases results
    sra_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .lo_idx   (lo_idx),
        .hi_idx   (hi_idx),
        .cmd      (cmd),
        .rd_idx   (rd_idx)
    );

    // slot table and per-slot processing
    sra_dpath #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS),
        .IW       (IW)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_idx        (rd_idx),
        .stat          (stat),
        .lo_idx        (lo_idx),
        .hi_idx        (hi_idx),
        .in_req_type   (s_tuser),
        .in_channel    (s_tdata[15:0]),
        .in_start_slot (s_tdata[22:16]),
        .in_end_slot   (s_tdata[29:23]),
        .status        (status),
        .conflict_slot (conflict_slot),
        .removed_count (removed_count),
        .empty_count   (empty_count),
        .foreign_count (foreign_count),
        .owned_mask    (owned_mask),
        .first_owned   (first_owned),
        .last_owned    (last_owned),
        .slot_owner    (slot_owner),
        .slot_first    (slot_first),
        .slot_last     (slot_last)
    );

    // result item packing, highest field first
    assign m_tdata = {slot_last, slot_first, slot_owner, last_owned, first_owned,
                      owned_mask, foreign_count, empty_count, removed_count,
                      conflict_slot, status};

endmodule

// ===== tb/slot_range_allocator_tb.sv =====
// self-checking testbench of the slot range allocator: directed and random requests
`timescale 1ns / 1ps

module slot_range_allocator_tb;
    import sra_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int CHANNELS   = CHANNELS_DEF;
    localparam int IDLE_LIMIT = 2000;   // cycles without any handshake before giving up
    localparam int RAND_ITEMS = 1700;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] channel;
        logic [6:0]  start_slot;
        logic [6:0]  end_slot;
    } request_t;

    // same layout as m_tdata, highest field first
    typedef struct packed {
        logic        slot_last;
        logic        slot_first;
        logic [15:0] slot_owner;
        logic [5:0]  last_owned;
        logic [5:0]  first_owned;
        logic [31:0] owned_mask;
        logic [5:0]  foreign_count;
        logic [5:0]  empty_count;
        logic [5:0]  removed_count;
        logic [5:0]  conflict_slot;
        logic [1:0]  status;
    } result_t;

    // tracks the slot table and the results still owed by the block
    class alloc_scoreboard;
        result_t     expected_q[$];
        int          mismatches;
        logic [15:0] owner      [SLOTS];
        bit          mark_first [SLOTS];
        bit          mark_last  [SLOTS];

        function new();
            mismatches = 0;
            foreach (owner[i]) begin
                owner[i]      = '0;
                mark_first[i] = 1'b0;
                mark_last[i]  = 1'b0;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // lowest owned slot gets the first mark, highest the last mark
        function void refresh_marks(logic [15:0] ch);
            int lo;
            int hi;
            lo = -1;
            hi = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (owner[i] == ch) begin
                    if (lo < 0) lo = i;
                    hi = i;
                end
            end
            if (lo < 0) return;
            for (int i = lo; i <= hi; i++) begin
                if (owner[i] == ch) begin
                    mark_first[i] = (i == lo);
                    mark_last[i]  = (i == hi);
                end
            end
        endfunction

        function result_t with_channel_view(logic [15:0] ch, result_t r);
            for (int i = 0; i < SLOTS; i++) begin
                if (owner[i] == ch) begin
                    if (i < 32) r.owned_mask[i] = 1'b1;
                    if (r.first_owned == 0) r.first_owned = 6'(i + 1);
                    r.last_owned = 6'(i + 1);
                end
            end
            return r;
        endfunction

        function result_t predict_response(request_t q);
            result_t r;
            bit      range_valid;
            int      s;
            int      e;
            int      hit;
            int      n_removed;
            int      n_empty;
            int      n_foreign;
            r = '0;
            s = int'(q.start_slot);
            e = int'(q.end_slot);
            if (q.req == REQ_READ) begin
                // channel and end slot play no part in a read
                if (s >= 1 && s <= SLOTS) begin
                    r.slot_owner = owner[s - 1];
                    r.slot_first = mark_first[s - 1];
                    r.slot_last  = mark_last[s - 1];
                end else begin
                    r.status = ST_RANGE;
                end
                return r;
            end
            if (q.channel == 0 || int'(q.channel) > CHANNELS) begin
                r.status = ST_CHANNEL;
                return r;
            end
            range_valid = (s >= 1) && (e <= SLOTS) && (s <= e);
            if (q.req == REQ_ADD) begin
                if (!range_valid) begin
                    r.status = ST_RANGE;
                end else begin
                    // slots the channel already holds count as free
                    hit = 0;
                    for (int k = s; k <= e; k++) begin
                        if (hit == 0 && owner[k - 1] != 0 && owner[k - 1] != q.channel)
                            hit = k;
                    end
                    if (hit != 0) begin
                        r.status        = ST_CONFLICT;
                        r.conflict_slot = 6'(hit);
                    end else begin
                        for (int k = s; k <= e; k++) owner[k - 1] = q.channel;
                        refresh_marks(q.channel);
                    end
                end
            end else if (q.req == REQ_REMOVE) begin
                if (!range_valid) begin
                    r.status = ST_RANGE;
                end else begin
                    n_removed = 0;
                    n_empty   = 0;
                    n_foreign = 0;
                    for (int k = s; k <= e; k++) begin
                        if (owner[k - 1] == q.channel) begin
                            owner[k - 1]      = '0;
                            mark_first[k - 1] = 1'b0;
                            mark_last[k - 1]  = 1'b0;
                            n_removed++;
                        end else if (owner[k - 1] == 0) begin
                            n_empty++;
                        end else begin
                            n_foreign++;
                        end
                    end
                    r.removed_count = 6'(n_removed);
                    r.empty_count   = 6'(n_empty);
                    r.foreign_count = 6'(n_foreign);
                end
                refresh_marks(q.channel);
            end
            return with_channel_view(q.channel, r);
        endfunction

        function void note_request(request_t q);
            expected_q.push_back(predict_response(q));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(logic [87:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (expected_q.size() == 0) begin
                mismatches++;
                $error("result with no request waiting: 0x%0h", raw);
                return;
            end
            want = expected_q.pop_front();
            check_field("status",        32'(want.status),        32'(got.status));
            check_field("conflict_slot", 32'(want.conflict_slot), 32'(got.conflict_slot));
            check_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
            check_field("empty_count",   32'(want.empty_count),   32'(got.empty_count));
            check_field("foreign_count", 32'(want.foreign_count), 32'(got.foreign_count));
            check_field("owned_mask",    want.owned_mask,         got.owned_mask);
            check_field("first_owned",   32'(want.first_owned),   32'(got.first_owned));
            check_field("last_owned",    32'(want.last_owned),    32'(got.last_owned));
            check_field("slot_owner",    32'(want.slot_owner),    32'(got.slot_owner));
            check_field("slot_first",    32'(want.slot_first),    32'(got.slot_first));
            check_field("slot_last",     32'(want.slot_last),     32'(got.slot_last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    alloc_scoreboard sb = new();
    int              idle_cycles = 0;
    int              rx_cycle    = 0;
    int              rx_hold     = 0;

    always #10 aclk = ~aclk;

    slot_range_allocator #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic request_t make_req(logic [1:0] req, int ch, int s, int e);
        request_t q;
        q.req        = req;
        q.channel    = 16'(ch);
        q.start_slot = 7'(s);
        q.end_slot   = 7'(e);
        return q;
    endfunction

    // mostly small well-formed ranges on a few busy channels, some junk
    function automatic request_t random_request();
        request_t q;
        int       pick;
        int       len;
        int       s;
        pick  = $urandom_range(0, 99);
        q.req = (pick < 35) ? REQ_ADD : (pick < 60) ? REQ_REMOVE :
                (pick < 75) ? REQ_QUERY : REQ_READ;
        pick = $urandom_range(0, 99);
        if (pick < 88)      q.channel = 16'($urandom_range(1, 6));
        else if (pick < 93) q.channel = 16'($urandom_range(CHANNELS - 5, CHANNELS + 1));
        else if (pick < 96) q.channel = '0;
        else                q.channel = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            s   = $urandom_range(1, SLOTS);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SLOTS) : $urandom_range(1, 6);
            q.start_slot = 7'(s);
            q.end_slot   = 7'((s + len - 1 > SLOTS) ? SLOTS : s + len - 1);
        end else begin
            q.start_slot = 7'($urandom_range(0, 127));
            q.end_slot   = 7'($urandom_range(0, 127));
        end
        return q;
    endfunction

    // called just after a falling edge, returns just after the falling edge that follows the accept
    task automatic send_request(request_t q);
        s_tvalid = 1'b1;
        s_tuser  = q.req;
        s_tdata  = {2'b00, q.end_slot, q.start_slot, q.channel};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(q);
        @(negedge aclk);
    endtask

    task automatic sender_gap(int cycles);
        s_tvalid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // hold the sender off until every owed result is back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.outstanding() > 0) @(negedge aclk);
    endtask

    // receiver: always ready, a fixed comb, coin flips and long stalls, in turn
    always @(negedge aclk) begin
        case ((rx_cycle / 400) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= (rx_cycle % 5) != 0 && (rx_cycle % 7) != 3;
            end
            2: begin
                m_tready <= $urandom_range(0, 1);
            end
            default: begin
                if (rx_hold > 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_hold - 1;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(5, 40);
                end
            end
        endcase
        rx_cycle <= rx_cycle + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("slot_range_allocator_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int burst_left;
        int gap;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty table, full range, conflicts, re-add, bad channels and ranges
        send_request(make_req(REQ_READ,   1,     1,   0));
        send_request(make_req(REQ_ADD,    1,     1,   SLOTS));
        send_request(make_req(REQ_QUERY,  1,     0,   0));
        send_request(make_req(REQ_READ,   0,     SLOTS, 0));
        send_request(make_req(REQ_ADD,    2,     5,   5));
        send_request(make_req(REQ_REMOVE, 2,     1,   SLOTS));
        send_request(make_req(REQ_REMOVE, 1,     10,  20));
        send_request(make_req(REQ_READ,   1,     9,   0));
        send_request(make_req(REQ_REMOVE, 1,     1,   SLOTS));
        send_request(make_req(REQ_ADD,    CHANNELS, 3, 7));
        send_request(make_req(REQ_ADD,    1,     5,   9));
        send_request(make_req(REQ_ADD,    CHANNELS, 1, 4));
        send_request(make_req(REQ_READ,   0,     1,   0));
        send_request(make_req(REQ_READ,   65535, 7,   127));
        send_request(make_req(REQ_ADD,    0,     1,   1));
        send_request(make_req(REQ_ADD,    CHANNELS + 1, 1, 1));
        send_request(make_req(REQ_QUERY,  65535, 127, 127));
        send_request(make_req(REQ_REMOVE, 0,     1,   2));
        send_request(make_req(REQ_ADD,    3,     0,   4));
        send_request(make_req(REQ_ADD,    3,     30,  SLOTS + 1));
        send_request(make_req(REQ_ADD,    3,     10,  9));
        send_request(make_req(REQ_REMOVE, CHANNELS, 127, 127));
        send_request(make_req(REQ_READ,   2,     0,   5));
        send_request(make_req(REQ_READ,   2,     SLOTS + 1, 5));
        send_request(make_req(REQ_QUERY,  CHANNELS, 0, 0));
        wait_drained();

        // random requests in bursts with random gaps
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 300 == 299) wait_drained();
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 8);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                sender_gap(gap);
            end
            burst_left--;
            send_request(random_request());
        end
        s_tvalid = 1'b0;

        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("slot_range_allocator_tb: PASS");
        end else begin
            $display("slot_range_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule
